// File: rtl/jdc_pkg.sv
// Shared types, constants and the days-before-month table for the Julian Day
// to calendar date unit. No dependencies.
package jdc_pkg;

   localparam int DAY_BITS = 23;

   // Transaction types.
   typedef struct packed {
      logic [DAY_BITS-1:0] day_number;
      logic [16:0]         seconds_after_noon;
   } req_type;

   typedef struct packed {
      logic signed [15:0] year;
      logic [3:0]         month;
      logic [4:0]         day_of_month;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
      logic               gregorian;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] year;
      logic [3:0]         month;
      logic [4:0]         day_of_month;
      logic               gregorian;
   } date_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } clock_type;

   localparam int LATENCY     = 9;
   localparam int TIME_STAGES = 5;

   // Time of day constants.
   localparam int SEC_WIDTH = 17;
   localparam int HALF_DAY  = 43200;
   localparam int SEC_MAX   = 86399;
   localparam int HOUR_SECS = 3600;
   localparam int MIN_SECS  = 60;
   localparam int REM_WIDTH = 12;

   // Exact reciprocal for sod / 3600 over 17-bit inputs.
   localparam int KH  = SEC_WIDTH + 12;
   localparam int MHW = SEC_WIDTH + 1;
   localparam longint unsigned MH_FULL =
      ((64'd1 << KH) + longint'(HOUR_SECS) - 1) / longint'(HOUR_SECS);
   localparam logic [MHW-1:0] MH = MHW'(MH_FULL);

   // Exact reciprocal for rem / 60 over 12-bit inputs.
   localparam int KM  = REM_WIDTH + 6;
   localparam int MMW = REM_WIDTH + 1;
   localparam longint unsigned MM_FULL =
      ((64'd1 << KM) + longint'(MIN_SECS) - 1) / longint'(MIN_SECS);
   localparam logic [MMW-1:0] MM = MMW'(MM_FULL);

   // Date path widths.
   localparam int ZW  = DAY_BITS + 1;
   localparam int X1W = ZW + 2;
   localparam int BW  = ZW + 1;
   localparam int X2W = BW + 5;
   localparam int CW  = X2W - 12;
   localparam int DW  = CW + 9;
   localparam int BDW = 10;
   localparam int X3W = BDW + 14;
   localparam int A1W = X1W - 17;
   localparam int EW  = 4;

   localparam int REFORM_DAY  = 2299161;
   localparam int A1_OFFSET   = 7468865;
   localparam int B_OFFSET    = 1524;
   localparam int C_OFFSET    = 2442;
   localparam int YEAR_EARLY  = 4715;
   localparam int YEAR_LATE   = 4716;
   localparam int DAYS_4YEARS = 1461;
   localparam int E_SCALE     = 10000;

   // floor((4z - 7468865) / 146097)
   localparam longint unsigned D1 = 146097;
   localparam int K1  = X1W + 18;
   localparam int M1W = X1W + 1;
   localparam int P1W = X1W + M1W;
   localparam longint unsigned M1_FULL = ((64'd1 << K1) + D1 - 1) / D1;
   localparam logic [M1W-1:0] M1 = M1W'(M1_FULL);

   // floor((20b - 2442) / 7305)
   localparam longint unsigned D2 = 7305;
   localparam int K2  = X2W + 13;
   localparam int M2W = X2W + 1;
   localparam int P2W = X2W + M2W;
   localparam longint unsigned M2_FULL = ((64'd1 << K2) + D2 - 1) / D2;
   localparam logic [M2W-1:0] M2 = M2W'(M2_FULL);

   // floor(10000(b - d) / 306001)
   localparam longint unsigned D3 = 306001;
   localparam int K3  = X3W + 19;
   localparam int M3W = X3W + 1;
   localparam int P3W = X3W + M3W;
   localparam longint unsigned M3_FULL = ((64'd1 << K3) + D3 - 1) / D3;
   localparam logic [M3W-1:0] M3 = M3W'(M3_FULL);

   // Days before month index e, floor(306001e / 10000), for e from 4 to 15.
   function automatic logic [BDW-1:0] day_offset(input logic [EW-1:0] e);
      logic [BDW-1:0] result;
      case (e)
         4'd4:    result = BDW'(122);
         4'd5:    result = BDW'(153);
         4'd6:    result = BDW'(183);
         4'd7:    result = BDW'(214);
         4'd8:    result = BDW'(244);
         4'd9:    result = BDW'(275);
         4'd10:   result = BDW'(306);
         4'd11:   result = BDW'(336);
         4'd12:   result = BDW'(367);
         4'd13:   result = BDW'(397);
         4'd14:   result = BDW'(428);
         4'd15:   result = BDW'(459);
         default: result = '0;
      endcase
      return result;
   endfunction

endpackage

// File: rtl/julian_day_to_calendar_date_unit.sv
// Julian Day to calendar date and time of day, fully pipelined.
// The response to an accepted transaction is strobed once it has passed through
// the date pipeline's nine register stages.
// Throughput is one transaction per cycle; busy is never asserted.
// Synchronous reset clears only the valid pipeline; the receiver cannot stall.
// Depends on jdc_pkg, jdc_date_path and jdc_time_path.
module julian_day_to_calendar_date_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  jdc_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output jdc_pkg::rsp_type  rsp_item
);
   import jdc_pkg::*;

   logic [LATENCY-1:0] valid_in, valid_ff;
   date_type           date_item;
   clock_type          clock_item;

   jdc_date_path u_date (
      .clock     (clock),
      .req_item  (req_item),
      .date_item (date_item)
   );

   jdc_time_path u_time (
      .clock              (clock),
      .seconds_after_noon (req_item.seconds_after_noon),
      .clock_item         (clock_item)
   );

   assign busy     = 1'b0;
   assign valid_in = {valid_ff[LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_strobe            = valid_ff[LATENCY-1];
   assign rsp_item.year         = date_item.year;
   assign rsp_item.month        = date_item.month;
   assign rsp_item.day_of_month = date_item.day_of_month;
   assign rsp_item.gregorian    = date_item.gregorian;
   assign rsp_item.hour         = clock_item.hour;
   assign rsp_item.minute       = clock_item.minute;
   assign rsp_item.second       = clock_item.second;

endmodule

// File: rtl/jdc_date_path.sv
// Nine-stage date pipeline: day number to year, month, day and calendar flag.
// Depends on jdc_pkg.
module jdc_date_path (
   input  logic               clock,
   input  jdc_pkg::req_type   req_item,
   output jdc_pkg::date_type  date_item
);
   import jdc_pkg::*;

   logic             carry;
   logic [ZW-1:0]    z1_in, z1_ff, z2_ff;
   logic             greg1_in, greg1_ff, greg2_ff, greg3_ff, greg4_ff;
   logic             greg5_ff, greg6_ff, greg7_ff, greg8_ff;
   logic [X1W-1:0]   x1_in, x1_ff;
   logic [P1W-1:0]   p1_in, p1_ff;
   logic [A1W-1:0]   a1;
   logic [BW-1:0]    adj, b3_in, b3_ff, b4_ff, b5_ff, b6_ff;
   logic [X2W-1:0]   x2_in, x2_ff;
   logic [P2W-1:0]   p2_in, p2_ff;
   logic [CW-1:0]    c6_in, c6_ff, c7_ff, c8_ff;
   logic [DW+1:0]    d_prod;
   logic [DW-1:0]    d6_in, d6_ff;
   logic [BW-1:0]    bd_full;
   logic [BDW-1:0]   bd7_in, bd7_ff, bd8_ff;
   logic [X3W-1:0]   x3_in, x3_ff;
   logic [P3W-1:0]   p3_in, p3_ff;
   logic [EW-1:0]    e;
   logic [3:0]       mon;
   logic [BDW-1:0]   dom_full;
   logic signed [CW:0] year_full;
   date_type         date_in, date_ff;

   always_comb begin
      carry    = req_item.seconds_after_noon >= SEC_WIDTH'(HALF_DAY);
      z1_in    = ZW'(req_item.day_number) + ZW'(carry);
      greg1_in = z1_in >= ZW'(REFORM_DAY);
      x1_in    = {z1_in, 2'b00} - X1W'(A1_OFFSET);

      p1_in = P1W'(x1_ff) * P1W'(M1);

      a1    = p1_ff[K1 +: A1W];
      adj   = BW'(a1) - BW'(a1 >> 2) + BW'(1);
      b3_in = BW'(z2_ff) + (greg2_ff ? adj : '0) + BW'(B_OFFSET);

      x2_in = X2W'({b3_ff, 4'b0000}) + X2W'({b3_ff, 2'b00}) - X2W'(C_OFFSET);

      p2_in = P2W'(x2_ff) * P2W'(M2);

      c6_in  = p2_ff[K2 +: CW];
      d_prod = (DW+2)'(c6_in) * (DW+2)'(DAYS_4YEARS);
      d6_in  = d_prod[DW+1:2];

      bd_full = b6_ff - d6_ff[BW-1:0];
      bd7_in  = bd_full[BDW-1:0];
      x3_in   = X3W'(bd7_in) * X3W'(E_SCALE);

      p3_in = P3W'(x3_ff) * P3W'(M3);

      e         = p3_ff[K3 +: EW];
      mon       = (e < 4'd14) ? e - 4'd1 : e - 4'd13;
      dom_full  = bd8_ff - day_offset(e);
      year_full = signed'({1'b0, c8_ff})
                  - ((mon > 4'd2) ? (CW+1)'(YEAR_LATE) : (CW+1)'(YEAR_EARLY));

      date_in.year         = year_full[15:0];
      date_in.month        = mon;
      date_in.day_of_month = dom_full[4:0];
      date_in.gregorian    = greg8_ff;
   end

   always_ff @(posedge clock) begin
      z1_ff    <= z1_in;
      greg1_ff <= greg1_in;
      x1_ff    <= x1_in;

      p1_ff    <= p1_in;
      z2_ff    <= z1_ff;
      greg2_ff <= greg1_ff;

      b3_ff    <= b3_in;
      greg3_ff <= greg2_ff;

      x2_ff    <= x2_in;
      b4_ff    <= b3_ff;
      greg4_ff <= greg3_ff;

      p2_ff    <= p2_in;
      b5_ff    <= b4_ff;
      greg5_ff <= greg4_ff;

      c6_ff    <= c6_in;
      d6_ff    <= d6_in;
      b6_ff    <= b5_ff;
      greg6_ff <= greg5_ff;

      bd7_ff   <= bd7_in;
      x3_ff    <= x3_in;
      c7_ff    <= c6_ff;
      greg7_ff <= greg6_ff;

      p3_ff    <= p3_in;
      bd8_ff   <= bd7_ff;
      c8_ff    <= c7_ff;
      greg8_ff <= greg7_ff;

      date_ff  <= date_in;
   end

   assign date_item = date_ff;

endmodule

// File: rtl/jdc_time_path.sv
// Time of day pipeline: seconds after noon to hour, minute and second,
// delayed to match the date pipeline. Depends on jdc_pkg.
module jdc_time_path (
   input  logic                clock,
   input  logic [16:0]         seconds_after_noon,
   output jdc_pkg::clock_type  clock_item
);
   import jdc_pkg::*;

   localparam int DELAY = LATENCY - TIME_STAGES;

   logic [SEC_WIDTH-1:0]       sec_sat;
   logic [SEC_WIDTH-1:0]       sod1_in, sod1_ff, sod2_ff;
   logic [SEC_WIDTH+MHW-1:0]   ph_in, ph_ff;
   logic [4:0]                 hour3_in, hour3_ff, hour4_ff;
   logic [SEC_WIDTH-1:0]       hprod;
   logic [SEC_WIDTH-1:0]       rem_full;
   logic [REM_WIDTH-1:0]       rem3_in, rem3_ff, rem4_ff;
   logic [REM_WIDTH+MMW-1:0]   pm_in, pm_ff;
   logic [5:0]                 minute;
   logic [REM_WIDTH-1:0]       mprod;
   logic [REM_WIDTH-1:0]       sec_full;
   clock_type                  time5_in, time5_ff;
   clock_type                  dly_ff [DELAY];

   always_comb begin
      sec_sat = (seconds_after_noon > SEC_WIDTH'(SEC_MAX)) ?
                SEC_WIDTH'(SEC_MAX) : seconds_after_noon;
      sod1_in = (sec_sat >= SEC_WIDTH'(HALF_DAY)) ?
                sec_sat - SEC_WIDTH'(HALF_DAY) : sec_sat + SEC_WIDTH'(HALF_DAY);

      ph_in = (SEC_WIDTH+MHW)'(sod1_ff) * (SEC_WIDTH+MHW)'(MH);

      hour3_in = ph_ff[KH +: 5];
      hprod    = SEC_WIDTH'(hour3_in) * SEC_WIDTH'(HOUR_SECS);
      rem_full = sod2_ff - hprod;
      rem3_in  = rem_full[REM_WIDTH-1:0];

      pm_in = (REM_WIDTH+MMW)'(rem3_ff) * (REM_WIDTH+MMW)'(MM);

      minute   = pm_ff[KM +: 6];
      mprod    = REM_WIDTH'(minute) * REM_WIDTH'(MIN_SECS);
      sec_full = rem4_ff - mprod;

      time5_in.hour   = hour4_ff;
      time5_in.minute = minute;
      time5_in.second = sec_full[5:0];
   end

   always_ff @(posedge clock) begin
      sod1_ff  <= sod1_in;
      ph_ff    <= ph_in;
      sod2_ff  <= sod1_ff;
      hour3_ff <= hour3_in;
      rem3_ff  <= rem3_in;
      pm_ff    <= pm_in;
      hour4_ff <= hour3_ff;
      rem4_ff  <= rem3_ff;
      time5_ff <= time5_in;
      dly_ff[0] <= time5_ff;
      for (int i = 1; i < DELAY; i++) begin
         dly_ff[i] <= dly_ff[i-1];
      end
   end

   assign clock_item = dly_ff[DELAY-1];

endmodule
